// ===== rtl/pes_dfr_pkg.sv =====
// Package: constants, register codes and shared types of the PES packet deframer.
`timescale 1ns / 1ps

package pes_dfr_pkg;

  localparam int unsigned POS_W     = 17;  // byte position within a packet
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned HDR_LEN   = 6;   // start code, id and length field
  localparam int unsigned MATCH_LEN = 4;   // start code plus id
  localparam int unsigned PEND_N    = 5;   // header bytes held after the first
  localparam int unsigned PEND_W    = 3;   // counts 0..PEND_N
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [BYTE_W-1:0] SYNC_ZERO = 8'h00;
  localparam logic [BYTE_W-1:0] SYNC_ONE  = 8'h01;

  // register index codes (paddr[2])
  localparam logic REG_STREAM_ID = 1'b0;
  localparam logic REG_ID_MASK   = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] stream_id;
    logic [BYTE_W-1:0] id_mask;
  } pes_dfr_cfg_t;

  // parser to output queue: one item, or a whole header
  typedef struct packed {
    logic              valid;
    logic              hdr;      // header complete, six items follow
    logic [BYTE_W-1:0] data;     // payload byte, or low length byte of a header
    logic              last;
    logic [BYTE_W-1:0] id_byte;
    logic [BYTE_W-1:0] len_hi;
  } pes_dfr_emit_t;

endpackage

// ===== rtl/pes_dfr_parser.sv =====
// Input register and header/payload parser of the PES packet deframer.
`timescale 1ns / 1ps

module pes_dfr_parser
  import pes_dfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [BYTE_W-1:0]   in_byte,
  input  pes_dfr_cfg_t        cfg,
  input  logic                space,
  output pes_dfr_emit_t       emit
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [POS_W-1:0]  size_r, size_nxt;
  logic [BYTE_W-1:0] seen_id_r, seen_id_nxt;
  logic [BYTE_W-1:0] len_high_r, len_high_nxt;

  logic              emits;
  logic              consume;
  logic [BYTE_W-1:0] ch;
  logic [BYTE_W-1:0] sync;
  logic [POS_W-1:0]  next_pos;
  logic [POS_W-1:0]  size_calc;
  logic              fin;
  logic              zero_len;

  assign emits    = (pos_r >= POS_W'(HDR_LEN - 1));
  assign consume  = in_valid_r && (!emits || space);
  assign in_stall = in_valid_r && !consume;

  always_comb begin
    pos_nxt      = pos_r;
    size_nxt     = size_r;
    seen_id_nxt  = seen_id_r;
    len_high_nxt = len_high_r;

    ch = in_byte_r;
    if (pos_r == POS_W'(MATCH_LEN - 1)) begin
      ch = in_byte_r & cfg.id_mask;
    end
    unique case (pos_r[1:0])
      2'd2:    sync = SYNC_ONE;
      2'd3:    sync = cfg.stream_id;
      default: sync = SYNC_ZERO;
    endcase

    next_pos  = pos_r + POS_W'(1);
    size_calc = {1'b0, len_high_r, in_byte_r} + POS_W'(HDR_LEN);
    zero_len  = (len_high_r == '0) && (in_byte_r == '0);
    fin       = (next_pos >= size_r) || (pos_r >= size_r);

    emit.valid   = consume && emits;
    emit.hdr     = (pos_r == POS_W'(HDR_LEN - 1));
    emit.data    = in_byte_r;
    emit.last    = emit.hdr ? zero_len : fin;
    emit.id_byte = seen_id_r;
    emit.len_hi  = len_high_r;

    if (consume) begin
      priority if (pos_r >= POS_W'(HDR_LEN)) begin
        pos_nxt = fin ? '0 : next_pos;
      end else if (pos_r < POS_W'(MATCH_LEN)) begin
        if (ch != sync) begin
          // resync: a zero byte already counts as two start code bytes
          pos_nxt = (ch == SYNC_ZERO) ? POS_W'(2) : '0;
        end else begin
          if (pos_r == POS_W'(MATCH_LEN - 1)) begin
            seen_id_nxt = in_byte_r;
          end
          pos_nxt = next_pos;
        end
      end else if (pos_r == POS_W'(MATCH_LEN)) begin
        len_high_nxt = in_byte_r;
        pos_nxt      = next_pos;
      end else begin
        size_nxt = size_calc;
        pos_nxt  = zero_len ? '0 : POS_W'(HDR_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      pos_r      <= '0;
      size_r     <= '0;
      seen_id_r  <= '0;
      len_high_r <= '0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      pos_r      <= pos_nxt;
      size_r     <= size_nxt;
      seen_id_r  <= seen_id_nxt;
      len_high_r <= len_high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

endmodule

// ===== rtl/pes_dfr_outq.sv =====
// Output register and header queue of the PES packet deframer.
`timescale 1ns / 1ps

module pes_dfr_outq
  import pes_dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pes_dfr_emit_t     emit,
  output logic              space,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_first,
  output logic              out_last
);

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_first_r, out_first_nxt;
  logic              out_last_r, out_last_nxt;
  logic [PEND_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic              pend_last_r, pend_last_nxt;
  logic [BYTE_W-1:0] pend_r   [PEND_N];
  logic [BYTE_W-1:0] pend_nxt [PEND_N];
  logic              slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign space     = (pend_cnt_r == '0) && slot_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_first_nxt = out_first_r;
    out_last_nxt  = out_last_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend_last_nxt = pend_last_r;
    for (int i = 0; i < PEND_N; i++) begin
      pend_nxt[i] = pend_r[i];
    end

    if (slot_free) begin
      if (pend_cnt_r != '0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = pend_r[0];
        out_first_nxt = 1'b0;
        out_last_nxt  = (pend_cnt_r == PEND_W'(1)) && pend_last_r;
        for (int i = 0; i < PEND_N - 1; i++) begin
          pend_nxt[i] = pend_r[i+1];
        end
        pend_cnt_nxt = pend_cnt_r - PEND_W'(1);
      end else if (emit.valid) begin
        out_valid_nxt = 1'b1;
        if (emit.hdr) begin
          out_byte_nxt  = SYNC_ZERO;
          out_first_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          pend_nxt[0]   = SYNC_ZERO;
          pend_nxt[1]   = SYNC_ONE;
          pend_nxt[2]   = emit.id_byte;
          pend_nxt[3]   = emit.len_hi;
          pend_nxt[4]   = emit.data;
          pend_cnt_nxt  = PEND_W'(PEND_N);
          pend_last_nxt = emit.last;
        end else begin
          out_byte_nxt  = emit.data;
          out_first_nxt = 1'b0;
          out_last_nxt  = emit.last;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_cnt_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r  <= out_byte_nxt;
    out_first_r <= out_first_nxt;
    out_last_r  <= out_last_nxt;
    pend_last_r <= pend_last_nxt;
    for (int i = 0; i < PEND_N; i++) begin
      pend_r[i] <= pend_nxt[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_first = out_first_r;
  assign out_last  = out_last_r;

endmodule

// ===== rtl/pes_packet_deframer_core.sv =====
// Top level of the PES packet deframer: register port, parser and output queue.
// Takes one byte item per cycle while in_stall is low, hunts for the start code
// 00 00 01 plus a stream id (received id ANDed with id_mask, then compared with
// stream_id), and streams out every byte of a matching packet with first/last
// marks. Bytes of the start code, id and length are held back until the length
// is complete; the sixth header byte then yields all six header items, which
// leave one by one through the single output register; the input stalls until
// they have all moved into it. Other bytes pass at one item per cycle while
// neither side stalls, via the input register and then the output register. A
// byte that breaks the start code or id is dropped and the match restarts (a
// zero byte counts as the first two start code bytes). A zero length field
// closes the packet on its sixth byte. stream_id lives at byte address 0 (reset
// 00), id_mask at 4 (reset FF); write them only while the block is idle.
`timescale 1ns / 1ps

module pes_packet_deframer_core
  import pes_dfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // byte input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  // packet output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_first,
  output logic              out_last
);

  logic [BYTE_W-1:0] stream_id_r;
  logic [BYTE_W-1:0] id_mask_r;
  logic              wr_en;
  pes_dfr_cfg_t      cfg;
  pes_dfr_emit_t     emit;
  logic              space;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register file: two byte-wide registers, index taken from paddr[2]
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_id_r <= '0;
      id_mask_r   <= '1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_STREAM_ID: stream_id_r <= pwdata[BYTE_W-1:0];
        REG_ID_MASK:   id_mask_r   <= pwdata[BYTE_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STREAM_ID: prdata = {{(DATA_W-BYTE_W){1'b0}}, stream_id_r};
      REG_ID_MASK:   prdata = {{(DATA_W-BYTE_W){1'b0}}, id_mask_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.stream_id = stream_id_r;
  assign cfg.id_mask   = id_mask_r;

  // header hunt and packet tracking
  pes_dfr_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .cfg      (cfg),
    .space    (space),
    .emit     (emit)
  );

  // output register plus queue for the header burst
  pes_dfr_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .emit      (emit),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_first (out_first),
    .out_last  (out_last)
  );

endmodule

// ===== verif/testbench.sv =====
// Testbench for the PES packet deframer: byte stimulus, packet prediction and checking.
`timescale 1ns / 1ps

module testbench;
  import pes_dfr_pkg::*;

  // One output beat of a deframed packet
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_first;
    logic              is_last;
  } pes_beat_t;

  // Predicts the deframer's output from the accepted byte stream and checks
  // each output beat against the oldest prediction.
  class pes_deframe_predictor;
    pes_beat_t         due_beats[$];
    logic [BYTE_W-1:0] sid;
    logic [BYTE_W-1:0] mask;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  pkt_size;
    logic [BYTE_W-1:0] id_seen;
    logic [BYTE_W-1:0] len_hi;
    int unsigned       fails;

    function new();
      sid      = 8'h00;
      mask     = 8'hFF;
      pos      = '0;
      pkt_size = '0;
      id_seen  = '0;
      len_hi   = '0;
      fails    = 0;
    endfunction

    function void set_reg(logic reg_idx, logic [BYTE_W-1:0] value);
      if (reg_idx == REG_STREAM_ID) sid = value;
      else mask = value;
    endfunction

    // Expected byte at each start code / id position
    function logic [BYTE_W-1:0] sync_at(int unsigned idx);
      case (idx)
        2: return SYNC_ONE;
        3: return sid;
        default: return SYNC_ZERO;
      endcase
    endfunction

    function void push(logic [BYTE_W-1:0] data, logic is_first, logic is_last);
      pes_beat_t beat;
      beat.data     = data;
      beat.is_first = is_first;
      beat.is_last  = is_last;
      due_beats.push_back(beat);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b);
      logic [POS_W-1:0]  nxt;
      logic [BYTE_W-1:0] ch;
      logic              fin;
      int unsigned       p;
      if (pos >= POS_W'(HDR_LEN)) begin
        nxt = pos + 1'b1;
        fin = (nxt >= pkt_size) || (pos >= pkt_size);
        push(b, 1'b0, fin);
        pos = fin ? '0 : nxt;
      end else if (pos < POS_W'(MATCH_LEN)) begin
        ch = (pos == 3) ? (b & mask) : b;
        if (ch != sync_at(pos)) begin
          // drop the byte, then skip leading header bytes equal to it
          p = 0;
          while (p < MATCH_LEN && sync_at(p) == ch) p++;
          pos = POS_W'(p);
        end else begin
          if (pos == 3) id_seen = b;
          pos = pos + 1'b1;
        end
      end else if (pos == 4) begin
        len_hi = b;
        pos    = POS_W'(5);
      end else begin
        pkt_size = {1'b0, len_hi, b} + POS_W'(HDR_LEN);
        fin      = (pkt_size == POS_W'(HDR_LEN));
        push(SYNC_ZERO, 1'b1, 1'b0);
        push(SYNC_ZERO, 1'b0, 1'b0);
        push(SYNC_ONE, 1'b0, 1'b0);
        push(id_seen, 1'b0, 1'b0);
        push(len_hi, 1'b0, 1'b0);
        push(b, 1'b0, fin);
        pos = fin ? '0 : POS_W'(HDR_LEN);
      end
    endfunction

    function void check_beat(logic [BYTE_W-1:0] data, logic is_first, logic is_last);
      pes_beat_t want;
      if (due_beats.size() == 0) begin
        $error("unexpected output item: out_byte %02h first %0b last %0b",
               data, is_first, is_last);
        fails++;
        return;
      end
      want = due_beats.pop_front();
      if (data !== want.data) begin
        $error("out_byte: expected %02h, got %02h", want.data, data);
        fails++;
      end
      if (is_first !== want.is_first) begin
        $error("out_first: expected %0b, got %0b", want.is_first, is_first);
        fails++;
      end
      if (is_last !== want.is_last) begin
        $error("out_last: expected %0b, got %0b", want.is_last, is_last);
        fails++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_byte;
  logic              out_first;
  logic              out_last;

  pes_deframe_predictor deframer;

  // calm: no idling on either side; squeeze_req: ask the receiver for a long hold-off
  bit          calm;
  bit          squeeze_req;
  int unsigned bytes_sent;

  pes_packet_deframer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_first (out_first),
    .out_last  (out_last)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the block
  // fills up and pushes back on its input.
  initial begin : receiver
    int unsigned hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold        = 80;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  // Output monitor: an item leaves when out_valid is high and out_stall low
  always @(posedge clk) begin
    if (rst_n && deframer != null && out_valid && !out_stall)
      deframer.check_beat(out_byte, out_first, out_last);
  end

  // Offer one byte; called and returns at a falling edge. in_valid stays up
  // across back-to-back items and only drops for an idle gap.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      in_byte  <= BYTE_W'($urandom_range(0, 255));
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    deframer.take_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Whole packet: start code, id, 16-bit length, then random payload
  task automatic send_packet(input logic [BYTE_W-1:0] id, input logic [15:0] len);
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ONE);
    send_byte(id);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    for (int unsigned i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // A header that breaks within the start code or id. Only the part before
  // the length field is ever sent, so a broken header can never turn into
  // an accidental packet of random length.
  task automatic send_broken();
    int unsigned       keep;
    logic [BYTE_W-1:0] b;
    keep = $urandom_range(0, 3);
    // an id mismatch is impossible when everything masks onto stream_id
    if (keep == 3 && deframer.mask == 8'h00 && deframer.sid == 8'h00) keep = 2;
    for (int unsigned i = 0; i < keep; i++) send_byte(deframer.sync_at(i));
    if (keep == 3) begin
      do b = BYTE_W'($urandom_range(0, 255)); while ((b & deframer.mask) == deframer.sid);
    end else begin
      do b = BYTE_W'($urandom_range(0, 255)); while (b == deframer.sync_at(keep));
      // a stray 01 after a lone zero would restart cleanly anyway; keep 00 as a resync case
    end
    send_byte(b);
  endtask

  // Random traffic: mostly well-formed packets whose id matches under the mask
  task automatic run_traffic(input int unsigned n_bytes, input bit with_long);
    int unsigned       start;
    int unsigned       pick;
    logic [BYTE_W-1:0] id;
    logic [15:0]       len;
    start = bytes_sent;
    if (with_long) begin
      id = deframer.sid | (BYTE_W'($urandom_range(0, 255)) & ~deframer.mask);
      send_packet(id, 16'h0100);
    end
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        id  = deframer.sid | (BYTE_W'($urandom_range(0, 255)) & ~deframer.mask);
        len = ($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 12))
                                           : 16'($urandom_range(13, 48));
        send_packet(id, len);
      end else if (pick < 85) begin
        send_broken();
      end else begin
        // noise that cannot start a match: never 00 or 01
        repeat ($urandom_range(1, 3)) send_byte(BYTE_W'($urandom_range(2, 255)));
      end
    end
  endtask

  // Let everything drain, plus a few cycles for bytes that produce nothing
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (deframer.due_beats.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Register write (setup then access), followed by a read-back
  task automatic write_reg(input logic reg_idx, input logic [BYTE_W-1:0] value);
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    deframer.set_reg(reg_idx, value);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[BYTE_W-1:0] !== value) begin
      $error("prdata: expected %02h, got %02h", value, got[BYTE_W-1:0]);
      deframer.fails++;
    end
  endtask

  task automatic configure(input logic [BYTE_W-1:0] sid, input logic [BYTE_W-1:0] mask);
    wait_idle();
    write_reg(REG_STREAM_ID, sid);
    write_reg(REG_ID_MASK, mask);
  endtask

  initial begin : stimulus
    int unsigned guard;
    deframer    = new();
    calm        = 1'b0;
    squeeze_req = 1'b0;
    bytes_sent  = 0;
    rst_n       = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    in_byte     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, on the reset register values (id 00, mask FF).
    // Zero-length packet: the sixth header byte closes it.
    send_packet(8'h00, 16'h0000);
    // Noise byte at the top of the range
    send_byte(8'hFF);
    // Extra leading zero: resync keeps the match, then a one-byte packet
    send_byte(SYNC_ZERO);
    send_packet(8'h00, 16'h0001);
    // Wrong id: dropped after the start code
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ONE);
    send_byte(8'hC0);
    // 01 where the second zero should be
    send_byte(SYNC_ZERO);
    send_byte(SYNC_ONE);

    // Masked id: video stream range, with one long hold-off at the start
    configure(8'hE0, 8'hF0);
    squeeze_req = 1'b1;
    run_traffic(50, 1'b0);

    // Top of both registers
    configure(8'hFF, 8'hFF);
    run_traffic(40, 1'b0);

    // Mask of zero: every id matches; no idling on either side here
    configure(8'h00, 8'h00);
    calm = 1'b1;
    run_traffic(40, 1'b0);
    calm = 1'b0;

    // Private stream id, with one packet whose length needs the high byte
    configure(8'hBD, 8'hFF);
    run_traffic(90, 1'b1);

    in_valid <= 1'b0;
    guard = 0;
    while (deframer.due_beats.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (deframer.due_beats.size() != 0) begin
      $error("%0d expected output items never arrived", deframer.due_beats.size());
      deframer.fails++;
    end
    if (deframer.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
